// ----- sv/rlm_pkg.sv -----
// Shared types and fixed widths of the RMS level meter.
package rlm_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int GAIN_W     = 16;
	localparam int LEVEL_W    = 16;
	localparam int MUL_W      = 16;
	localparam int PROD_W     = 2 * MUL_W;
	localparam int MEAN_W     = 31;
	localparam int ROOT_W     = 16;
	localparam int RAD_W      = 2 * ROOT_W;
	localparam int GAIN_FRAC  = 8;
	localparam int SCALED_W   = PROD_W - GAIN_FRAC;
	localparam int FULL_SCALE = 32768;
	localparam int GAIN_RESET = 256;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_DIVIDE,
		ST_ROOT,
		ST_SCALE,
		ST_PUSH
	} state_t;

	typedef struct packed {
		logic start;
	} unit_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

endpackage

// ----- sv/rlm_sample_if.sv -----
// Sample channel: valid, ready, one audio word and a block_end flag.
interface rlm_sample_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [rlm_pkg::SAMPLE_W-1:0]  sample;
	logic                                 block_end;

	modport source(output valid, sample, block_end, input ready);
	modport sink(input valid, sample, block_end, output ready);
endinterface

// ----- sv/rlm_level_if.sv -----
// Level channel: valid, ready and one result word.
interface rlm_level_if;
	logic                          valid;
	logic                          ready;
	logic [rlm_pkg::LEVEL_W-1:0]   level;

	modport source(output valid, level, input ready);
	modport sink(input valid, level, output ready);
endinterface

// ----- sv/rlm_mul.sv -----
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
module rlm_mul (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rlm_pkg::unit_ctl_t             ctl,
	input  logic [rlm_pkg::MUL_W-1:0]      a,
	input  logic [rlm_pkg::MUL_W-1:0]      b,
	output rlm_pkg::unit_sts_t             sts,
	output logic [rlm_pkg::PROD_W-1:0]     product
);
	localparam int W   = rlm_pkg::MUL_W;
	localparam int CW  = $clog2(W);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  a_q;
	logic [W-1:0]  b_q;
	logic [W-1:0]  hi_q;
	logic [W-1:0]  lo_q;
	logic [W:0]    part;

	// add the multiplicand into the upper half when the current bit is set
	assign part = {1'b0, hi_q} + (b_q[0] ? {1'b0, a_q} : '0);

	// sequence the iterations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// load the operands, then shift the partial product right
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			a_q  <= a;
			b_q  <= b;
			hi_q <= '0;
			lo_q <= '0;
		end else if (busy_q) begin
			b_q  <= b_q >> 1;
			hi_q <= part[W:1];
			lo_q <= {part[0], lo_q[W-1:1]};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign product  = {hi_q, lo_q};

endmodule

// ----- sv/rlm_div.sv -----
// Restoring divider, one quotient bit per cycle.
module rlm_div #(
	parameter int DEND_W = 41,
	parameter int DSOR_W = 11
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rlm_pkg::unit_ctl_t ctl,
	input  logic [DEND_W-1:0]  dividend,
	input  logic [DSOR_W-1:0]  divisor,
	output rlm_pkg::unit_sts_t sts,
	output logic [DEND_W-1:0]  quotient
);
	localparam int CW = $clog2(DEND_W);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [DEND_W-1:0] work_q;
	logic [DSOR_W-1:0] rem_q;
	logic [DSOR_W-1:0] dsor_q;
	logic [DSOR_W:0]   trial;
	logic [DSOR_W:0]   diff;
	logic              fits;

	// bring down the next dividend bit and try the subtraction
	assign trial = {rem_q, work_q[DEND_W-1]};
	assign diff  = trial - {1'b0, dsor_q};
	assign fits  = trial >= {1'b0, dsor_q};

	// sequence the iterations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DEND_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift quotient bits in as dividend bits leave
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			work_q <= dividend;
			rem_q  <= '0;
			dsor_q <= divisor;
		end else if (busy_q) begin
			rem_q  <= fits ? diff[DSOR_W-1:0] : trial[DSOR_W-1:0];
			work_q <= {work_q[DEND_W-2:0], fits};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quotient = work_q;

endmodule

// ----- sv/rlm_sqrt.sv -----
// Integer square root, one root bit (two radicand bits) per cycle.
module rlm_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rlm_pkg::unit_ctl_t            ctl,
	input  logic [rlm_pkg::MEAN_W-1:0]    radicand,
	output rlm_pkg::unit_sts_t            sts,
	output logic [rlm_pkg::ROOT_W-1:0]    root
);
	localparam int RW  = rlm_pkg::ROOT_W;
	localparam int AW  = rlm_pkg::RAD_W;
	localparam int CW  = $clog2(RW);
	localparam int REM_W = RW + 2;

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [AW-1:0]    rad_q;
	logic [REM_W-1:0] rem_q;
	logic [RW-1:0]    root_q;
	logic [REM_W+1:0] pair;
	logic [REM_W+1:0] test;
	logic [REM_W+1:0] diff;
	logic             fits;

	// bring down two radicand bits and test against 4*root+1
	assign pair = {rem_q, rad_q[AW-1:AW-2]};
	assign test = {2'b00, root_q, 2'b01};
	assign diff = pair - test;
	assign fits = pair >= test;

	// sequence the iterations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(RW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// advance one root bit
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rad_q  <= AW'(radicand);
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? diff[REM_W-1:0] : pair[REM_W-1:0];
			root_q <= {root_q[RW-2:0], fits};
			rad_q  <= {rad_q[AW-3:0], 2'b00};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign root     = root_q;

endmodule

// ----- sv/rms_level_meter.sv -----
// Top level of the RMS level meter: control, block sums and output register.
// Each sample word is squared by a bit-serial multiplier and added to the block
// sum; a plain sample passes through accept, launch, 16 multiplier steps and
// accumulate. On the last word of a block (block_end set, or MAX_BLOCK words
// taken) the mean is formed by a restoring divider at one bit per cycle, its
// root by a 16-step digit-by-digit unit, and the Q8.8 gain by another 16-step
// pass of the shared multiplier. The level is saturated at 32768 (1.0) and held
// in an output register; the next sample word is taken while it waits. The gain
// register resets to 256 (unity) and is written whenever cfg_we is high.
module rms_level_meter #(
	parameter int MAX_BLOCK = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	rlm_sample_if.sink                    sample_ch,
	rlm_level_if.source                   level_ch,
	input  logic                          cfg_we,
	input  logic [rlm_pkg::GAIN_W-1:0]    cfg_wdata
);
	localparam int CNT_W = $clog2(MAX_BLOCK + 1);
	localparam int SUM_W = 31 + $clog2(MAX_BLOCK);
	localparam int MW    = rlm_pkg::MUL_W;

	rlm_pkg::state_t              state_q;
	rlm_pkg::state_t              state_d;
	logic                         start_q;
	logic                         start_d;
	logic [rlm_pkg::GAIN_W-1:0]   gain_q;
	logic [MW-1:0]                mag_q;
	logic                         last_q;
	logic [SUM_W-1:0]             sum_q;
	logic [CNT_W-1:0]             count_q;
	logic [CNT_W-1:0]             count_inc;
	logic                         out_valid_q;
	logic [rlm_pkg::LEVEL_W-1:0]  level_q;
	logic                         accept;
	logic                         push;
	logic [MW-1:0]                magnitude;

	rlm_pkg::unit_ctl_t           mul_ctl;
	rlm_pkg::unit_ctl_t           div_ctl;
	rlm_pkg::unit_ctl_t           sqrt_ctl;
	rlm_pkg::unit_sts_t           mul_sts;
	rlm_pkg::unit_sts_t           div_sts;
	rlm_pkg::unit_sts_t           sqrt_sts;
	logic [MW-1:0]                mul_a;
	logic [MW-1:0]                mul_b;
	logic [rlm_pkg::PROD_W-1:0]   product;
	logic [SUM_W-1:0]             quotient;
	logic [rlm_pkg::ROOT_W-1:0]   root;
	logic [rlm_pkg::SCALED_W-1:0] scaled;
	logic [rlm_pkg::LEVEL_W-1:0]  level_sat;

	assign accept          = sample_ch.valid && sample_ch.ready;
	assign sample_ch.ready = (state_q == rlm_pkg::ST_IDLE);
	assign count_inc       = count_q + 1'b1;
	assign magnitude       = sample_ch.sample[rlm_pkg::SAMPLE_W-1]
		? MW'(0) - MW'($unsigned(sample_ch.sample))
		: MW'($unsigned(sample_ch.sample));

	// share the multiplier between squaring and gain
	assign mul_a = (state_q == rlm_pkg::ST_SCALE) ? MW'(root) : mag_q;
	assign mul_b = (state_q == rlm_pkg::ST_SCALE) ? MW'(gain_q) : mag_q;

	assign mul_ctl.start  = start_q && (state_q == rlm_pkg::ST_SQUARE ||
		state_q == rlm_pkg::ST_SCALE);
	assign div_ctl.start  = start_q && (state_q == rlm_pkg::ST_DIVIDE);
	assign sqrt_ctl.start = start_q && (state_q == rlm_pkg::ST_ROOT);

	rlm_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mul_ctl),
		.a       (mul_a),
		.b       (mul_b),
		.sts     (mul_sts),
		.product (product)
	);

	rlm_div #(
		.DEND_W (SUM_W),
		.DSOR_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (sum_q),
		.divisor  (count_q),
		.sts      (div_sts),
		.quotient (quotient)
	);

	rlm_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (sqrt_ctl),
		.radicand (quotient[rlm_pkg::MEAN_W-1:0]),
		.sts      (sqrt_sts),
		.root     (root)
	);

	// drop the fraction of the gain and saturate at full scale
	assign scaled    = product[rlm_pkg::GAIN_FRAC +: rlm_pkg::SCALED_W];
	assign level_sat = (scaled > rlm_pkg::SCALED_W'(rlm_pkg::FULL_SCALE))
		? rlm_pkg::LEVEL_W'(rlm_pkg::FULL_SCALE) : scaled[rlm_pkg::LEVEL_W-1:0];
	assign push      = (state_q == rlm_pkg::ST_PUSH) && (!out_valid_q || level_ch.ready);

	// next state and unit launch
	always_comb begin
		state_d = state_q;
		start_d = 1'b0;
		unique case (state_q)
			rlm_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = rlm_pkg::ST_SQUARE;
					start_d = 1'b1;
				end
			end
			rlm_pkg::ST_SQUARE: begin
				if (mul_sts.done) begin
					if (last_q || count_inc == CNT_W'(MAX_BLOCK)) begin
						state_d = rlm_pkg::ST_DIVIDE;
						start_d = 1'b1;
					end else begin
						state_d = rlm_pkg::ST_IDLE;
					end
				end
			end
			rlm_pkg::ST_DIVIDE: begin
				if (div_sts.done) begin
					state_d = rlm_pkg::ST_ROOT;
					start_d = 1'b1;
				end
			end
			rlm_pkg::ST_ROOT: begin
				if (sqrt_sts.done) begin
					state_d = rlm_pkg::ST_SCALE;
					start_d = 1'b1;
				end
			end
			rlm_pkg::ST_SCALE: begin
				if (mul_sts.done) begin
					state_d = rlm_pkg::ST_PUSH;
				end
			end
			rlm_pkg::ST_PUSH: begin
				if (push) begin
					state_d = rlm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rlm_pkg::ST_IDLE;
			end
		endcase
	end

	// hold state and launch pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rlm_pkg::ST_IDLE;
			start_q <= 1'b0;
		end else begin
			state_q <= state_d;
			start_q <= start_d;
		end
	end

	// gain register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= rlm_pkg::GAIN_W'(rlm_pkg::GAIN_RESET);
		end else if (cfg_we) begin
			gain_q <= cfg_wdata;
		end
	end

	// capture the incoming word
	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q  <= magnitude;
			last_q <= sample_ch.block_end;
		end
	end

	// accumulate the block, clear it once the divider has finished
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
		end else if (state_q == rlm_pkg::ST_SQUARE && mul_sts.done) begin
			sum_q   <= sum_q + SUM_W'(product);
			count_q <= count_inc;
		end else if (state_q == rlm_pkg::ST_DIVIDE && div_sts.done) begin
			sum_q   <= '0;
			count_q <= '0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (level_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			level_q <= level_sat;
		end
	end

	assign level_ch.valid = out_valid_q;
	assign level_ch.level = level_q;

	// the block count never passes the block length
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_BLOCK))
		else $error("block count beyond MAX_BLOCK");

	// no unit is running while a new word may be taken
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rlm_pkg::ST_IDLE |-> !mul_sts.busy && !div_sts.busy && !sqrt_sts.busy)
		else $error("unit busy while idle");

	// the multiplier reports only in the states that use it
	a_mul_owner: assert property (@(posedge clk) disable iff (!arst_n)
		mul_sts.done |-> state_q == rlm_pkg::ST_SQUARE || state_q == rlm_pkg::ST_SCALE)
		else $error("multiplier finished outside its states");

	// the sums are cleared once the mean has been taken
	a_block_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rlm_pkg::ST_DIVIDE && div_sts.done |=> count_q == '0 && sum_q == '0)
		else $error("block sums not cleared");

	// a launch lasts one cycle
	a_start_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |=> !start_q)
		else $error("launch held for more than one cycle");

endmodule
